[rtl/lhbp_pkg.sv]
`timescale 1ns / 1ps
// lhbp_pkg: shared constants for the local history branch predictor.
// Holds operation codes, fixed field widths and parameter defaults; no dependencies.
package lhbp_pkg;

    // Fixed widths of the channel fields
    localparam int OP_W        = 2;
    localparam int SLOT_IN_W   = 12;
    localparam int TARGET_IN_W = 32;
    localparam int TOTAL_W     = 32;

    // Operation codes
    localparam logic [OP_W-1:0] OP_COND_TAKEN     = 2'd0;
    localparam logic [OP_W-1:0] OP_COND_NOT_TAKEN = 2'd1;
    localparam logic [OP_W-1:0] OP_INDIRECT_JUMP  = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED         = 2'd3;

    // Two-bit counter limits (0 = strongly taken, 3 = strongly not taken)
    localparam logic [1:0] CTR_MIN = 2'd0;
    localparam logic [1:0] CTR_MAX = 2'd3;

    // Parameter defaults
    localparam int SLOT_COUNT_DEF   = 4096;
    localparam int HISTORY_BITS_DEF = 4;
    localparam int TARGET_BITS_DEF  = 32;

endpackage

[rtl/local_history_branch_predictor_unit.sv]
`timescale 1ns / 1ps
// local_history_branch_predictor_unit: two-level local branch predictor with a
// last-target buffer. Depends on lhbp_pkg.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one branch outcome per item:
//   operation, slot and resolved target. Output channel (o_valid / i_stall)
//   returns one result per item: mispredict flag and the four running totals.
//   An item is taken at a clock edge with valid high and stall low.
//
//   The slot table is read into a register at the accepting edge, and the
//   update lands in the output register when the item leaves the read
//   stage. Throughput is one item per cycle while the receiver does not
//   stall and no clear pass runs, set by the single write port of the slot
//   table; back-to-back items to the same slot are served from a one-entry write bypass.
//
//   After reset (i_rst_n low, synchronous) the slot table is cleared by a
//   pass over all SLOT_COUNT rows, one row per cycle; o_stall stays high
//   until the pass ends. The totals and all control state clear at once.
//
//   When the receiver stalls, the result is held in the output register; one
//   more item may wait in the read stage, after which o_stall goes high.
module local_history_branch_predictor_unit
    #(
    parameter int SLOT_COUNT   = lhbp_pkg::SLOT_COUNT_DEF,
    parameter int HISTORY_BITS = lhbp_pkg::HISTORY_BITS_DEF,
    parameter int TARGET_BITS  = lhbp_pkg::TARGET_BITS_DEF
    )
    (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [lhbp_pkg::OP_W-1:0]         i_operation,
    input  logic [lhbp_pkg::SLOT_IN_W-1:0]    i_slot,
    input  logic [lhbp_pkg::TARGET_IN_W-1:0]  i_actual_target,
    // output channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_mispredict,
    output logic [lhbp_pkg::TOTAL_W-1:0]      o_cond_exec_count,
    output logic [lhbp_pkg::TOTAL_W-1:0]      o_cond_miss_count,
    output logic [lhbp_pkg::TOTAL_W-1:0]      o_jump_exec_count,
    output logic [lhbp_pkg::TOTAL_W-1:0]      o_jump_miss_count
    );

    import lhbp_pkg::*;

    // Row layout: {target, counters, history}
    localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CTR_W   = 2 << HISTORY_BITS;
    localparam int POS_W   = HISTORY_BITS + 1;
    localparam int CTR_LSB = HISTORY_BITS;
    localparam int TGT_LSB = HISTORY_BITS + CTR_W;
    localparam int ROW_W   = TARGET_BITS + CTR_W + HISTORY_BITS;

    // Slot reduction by reciprocal multiply when the table size is not a power of two
    localparam int    RECIP_SHIFT = 24;
    localparam int    PROD_W      = RECIP_SHIFT + SLOT_IN_W;
    localparam longint RECIP_MUL  = (64'd1 << RECIP_SHIFT) / SLOT_COUNT + 1;
    localparam bit    SLOT_POW2   = (SLOT_COUNT & (SLOT_COUNT - 1)) == 0;

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    logic                 r_clr_active;
    logic [SLOT_W-1:0]    r_clr_addr;
    logic                 r_s1_valid;
    logic [OP_W-1:0]      r_s1_op;
    logic [SLOT_W-1:0]    r_s1_idx;
    logic [TARGET_BITS-1:0] r_s1_target;
    logic [ROW_W-1:0]     r_rd_row;
    logic                 r_byp_valid;
    logic [SLOT_W-1:0]    r_byp_idx;
    logic [ROW_W-1:0]     r_byp_row;
    logic                 r_out_valid;
    logic                 r_out_miss;
    logic [TOTAL_W-1:0]   r_cond_exec;
    logic [TOTAL_W-1:0]   r_cond_miss;
    logic [TOTAL_W-1:0]   r_jump_exec;
    logic [TOTAL_W-1:0]   r_jump_miss;

    logic                 out_free;
    logic                 s1_adv;
    logic                 in_acc;
    logic [SLOT_W-1:0]    in_idx;
    logic [TARGET_BITS-1:0] in_target;

    assign out_free = !r_out_valid || !i_stall;
    assign s1_adv   = r_s1_valid && out_free;
    assign o_stall  = r_clr_active || (r_s1_valid && !out_free);
    assign in_acc   = i_valid && !o_stall;

    // ------------------------------------------------------------------
    // Slot index and target masking
    // ------------------------------------------------------------------
    generate
        if (SLOT_COUNT >= (1 << SLOT_IN_W)) begin : g_idx_wide
            assign in_idx = SLOT_W'(i_slot);
        end else if (SLOT_POW2) begin : g_idx_mask
            assign in_idx = i_slot[SLOT_W-1:0];
        end else begin : g_idx_recip
            // quotient is exact for every 12-bit slot value, so no correction step
            logic [PROD_W-1:0]    w_prod;
            logic [SLOT_IN_W-1:0] w_quo;
            logic [PROD_W-1:0]    w_rem;
            assign w_prod = PROD_W'(i_slot) * PROD_W'(RECIP_MUL);
            assign w_quo  = w_prod[RECIP_SHIFT +: SLOT_IN_W];
            assign w_rem  = PROD_W'(i_slot) - PROD_W'(w_quo) * PROD_W'(SLOT_COUNT);
            assign in_idx = w_rem[SLOT_W-1:0];
        end
    endgenerate

    generate
        if (TARGET_BITS <= TARGET_IN_W) begin : g_tgt_trunc
            assign in_target = i_actual_target[TARGET_BITS-1:0];
        end else begin : g_tgt_ext
            assign in_target = TARGET_BITS'(i_actual_target);
        end
    endgenerate

    // ------------------------------------------------------------------
    // Update logic on the item in the read stage
    // ------------------------------------------------------------------
    logic [ROW_W-1:0]        cur_row;
    logic [HISTORY_BITS-1:0] cur_hist;
    logic [CTR_W-1:0]        cur_ctrs;
    logic [TARGET_BITS-1:0]  cur_tgt;
    logic [POS_W-1:0]        ctr_pos;
    logic [1:0]              cur_ctr;
    logic [HISTORY_BITS:0]   hist_shift;
    logic                    taken;
    logic                    n_miss;
    logic [1:0]              n_ctr;
    logic [HISTORY_BITS-1:0] n_hist;
    logic [CTR_W-1:0]        n_ctrs;
    logic [TARGET_BITS-1:0]  n_tgt;
    logic [ROW_W-1:0]        n_row;
    logic [TOTAL_W-1:0]      n_cond_exec;
    logic [TOTAL_W-1:0]      n_cond_miss;
    logic [TOTAL_W-1:0]      n_jump_exec;
    logic [TOTAL_W-1:0]      n_jump_miss;

    // latest row: bypass covers a write made at the edge of this item's read
    assign cur_row  = (r_byp_valid && (r_byp_idx == r_s1_idx)) ? r_byp_row : r_rd_row;
    assign cur_hist = cur_row[HISTORY_BITS-1:0];
    assign cur_ctrs = cur_row[CTR_LSB +: CTR_W];
    assign cur_tgt  = cur_row[TGT_LSB +: TARGET_BITS];
    assign ctr_pos  = {cur_hist, 1'b0};
    assign cur_ctr  = cur_ctrs[ctr_pos +: 2];
    assign taken    = (r_s1_op == OP_COND_TAKEN);
    assign hist_shift = {cur_hist, taken};

    always_comb begin
        n_miss      = 1'b0;
        n_ctr       = cur_ctr;
        n_hist      = cur_hist;
        n_ctrs      = cur_ctrs;
        n_tgt       = cur_tgt;
        n_cond_exec = r_cond_exec;
        n_cond_miss = r_cond_miss;
        n_jump_exec = r_jump_exec;
        n_jump_miss = r_jump_miss;
        unique case (r_s1_op)
            OP_COND_TAKEN, OP_COND_NOT_TAKEN: begin
                // counter bit 1 set predicts not taken
                n_miss = (cur_ctr[1] == taken);
                if (taken) begin
                    n_ctr = (cur_ctr != CTR_MIN) ? cur_ctr - 2'd1 : CTR_MIN;
                end else begin
                    n_ctr = (cur_ctr != CTR_MAX) ? cur_ctr + 2'd1 : CTR_MAX;
                end
                n_ctrs[ctr_pos +: 2] = n_ctr;
                n_hist      = hist_shift[HISTORY_BITS-1:0];
                n_cond_exec = r_cond_exec + TOTAL_W'(1);
                n_cond_miss = r_cond_miss + TOTAL_W'(n_miss);
            end
            OP_INDIRECT_JUMP: begin
                n_miss      = (cur_tgt != r_s1_target);
                n_tgt       = r_s1_target;
                n_jump_exec = r_jump_exec + TOTAL_W'(1);
                n_jump_miss = r_jump_miss + TOTAL_W'(n_miss);
            end
            OP_UNUSED: begin
                n_miss = 1'b0;
            end
            default: begin
                n_miss = 1'b0;
            end
        endcase
        n_row = {n_tgt, n_ctrs, n_hist};
    end

    // ------------------------------------------------------------------
    // Slot table: one write port (clear pass or update), one registered read
    // ------------------------------------------------------------------
    logic [ROW_W-1:0]  mem [SLOT_COUNT];
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [ROW_W-1:0]  wr_data;

    assign wr_en   = r_clr_active || s1_adv;
    assign wr_addr = r_clr_active ? r_clr_addr : r_s1_idx;
    assign wr_data = r_clr_active ? '0 : n_row;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (in_acc) begin
            r_rd_row <= mem[in_idx];
        end
    end

    // ------------------------------------------------------------------
    // Clear pass after reset
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            r_clr_addr <= r_clr_addr + SLOT_W'(1);
            if (r_clr_addr == SLOT_W'(SLOT_COUNT - 1)) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Read stage
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op     <= i_operation;
            r_s1_idx    <= in_idx;
            r_s1_target <= in_target;
        end
    end

    // Write bypass: last row written by an item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_valid <= 1'b0;
        end else if (s1_adv) begin
            r_byp_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_byp_idx <= r_s1_idx;
            r_byp_row <= n_row;
        end
    end

    // ------------------------------------------------------------------
    // Totals and output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cond_exec <= '0;
            r_cond_miss <= '0;
            r_jump_exec <= '0;
            r_jump_miss <= '0;
        end else if (s1_adv) begin
            r_cond_exec <= n_cond_exec;
            r_cond_miss <= n_cond_miss;
            r_jump_exec <= n_jump_exec;
            r_jump_miss <= n_jump_miss;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_miss <= n_miss;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_mispredict      = r_out_miss;
    assign o_cond_exec_count = r_cond_exec;
    assign o_cond_miss_count = r_cond_miss;
    assign o_jump_exec_count = r_jump_exec;
    assign o_jump_miss_count = r_jump_miss;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // no item may be in flight while the table is being cleared
    a_no_item_during_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> !r_s1_valid && !r_out_valid)
        else $error("item in flight during table clear");

    // totals only move when an item leaves the read stage
    a_totals_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_adv |=> $stable(r_cond_exec) && $stable(r_cond_miss)
                    && $stable(r_jump_exec) && $stable(r_jump_miss))
        else $error("totals changed without an item");

    // a conditional item bumps the conditional count by exactly one
    a_cond_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && (r_s1_op == OP_COND_TAKEN || r_s1_op == OP_COND_NOT_TAKEN)
        |=> r_cond_exec == $past(r_cond_exec) + TOTAL_W'(1))
        else $error("conditional count not incremented");

    // after an indirect jump the bypass row holds the resolved target
    a_jump_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && r_s1_op == OP_INDIRECT_JUMP
        |=> r_byp_row[TGT_LSB +: TARGET_BITS] == $past(r_s1_target))
        else $error("indirect target not recorded");

    // a result appears only from an item leaving the read stage
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(s1_adv))
        else $error("result without a source item");

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking testbench for local_history_branch_predictor_unit.
// Holds a predictor scoreboard class and plain driver tasks; depends on lhbp_pkg and the RTL.
module tb;
    import lhbp_pkg::*;

    localparam int SLOTS       = SLOT_COUNT_DEF;
    localparam int HIST_W      = HISTORY_BITS_DEF;
    localparam int RANDOM_ITEMS = 1600;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 20000;
    localparam int POOL        = 8;

    typedef struct {
        bit        mispredict;
        bit [31:0] cond_exec;
        bit [31:0] cond_miss;
        bit [31:0] jump_exec;
        bit [31:0] jump_miss;
    } branch_result_t;

    // Scoreboard: mirrors the predictor state and queues expected results
    class bp_scoreboard;
        bit [HIST_W-1:0]               local_hist [SLOTS];
        bit [(1<<HIST_W)-1:0][1:0]     dir_ctr    [SLOTS];
        bit [TARGET_IN_W-1:0]          last_tgt   [SLOTS];
        branch_result_t                running;
        branch_result_t                expected_results [$];
        int errors;
        int checked;
        int misses_seen;

        function int pending();
            return expected_results.size();
        endfunction

        // predict the result of one accepted branch outcome
        function void note_outcome(logic [OP_W-1:0] op, logic [SLOT_IN_W-1:0] slot,
                                   logic [TARGET_IN_W-1:0] tgt);
            bit [HIST_W-1:0] h;
            bit [1:0]        c;
            bit              taken;
            running.mispredict = 1'b0;
            case (op)
                OP_COND_TAKEN, OP_COND_NOT_TAKEN: begin
                    taken = (op == OP_COND_TAKEN);
                    h = local_hist[slot];
                    c = dir_ctr[slot][h];
                    // judged on the counter before its update; 0 and 1 mean taken
                    running.mispredict = ((c[1] == 1'b0) != taken);
                    if (taken && c != CTR_MIN)
                        c = c - 2'd1;
                    else if (!taken && c != CTR_MAX)
                        c = c + 2'd1;
                    dir_ctr[slot][h] = c;
                    local_hist[slot] = {h[HIST_W-2:0], taken};
                    running.cond_exec++;
                    if (running.mispredict)
                        running.cond_miss++;
                end
                OP_INDIRECT_JUMP: begin
                    if (last_tgt[slot] != tgt) begin
                        last_tgt[slot] = tgt;
                        running.mispredict = 1'b1;
                        running.jump_miss++;
                    end
                    running.jump_exec++;
                end
                default: ; // unused code: no state change
            endcase
            expected_results.push_back(running);
        endfunction

        function void compare_field(string name, bit [31:0] want, bit [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t ns: mismatch on %s: expected 0x%08h, actual 0x%08h",
                         $realtime, name, want, got);
            end
        endfunction

        // compare one accepted result with the oldest expectation
        function void check_result(logic mis, logic [31:0] ce, logic [31:0] cm,
                                   logic [31:0] je, logic [31:0] jm);
            branch_result_t e;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result: expected none, actual mis=%b ce=%0d",
                         $realtime, mis, ce);
                return;
            end
            e = expected_results.pop_front();
            checked++;
            if (mis === 1'b1)
                misses_seen++;
            compare_field("mispredict", {31'd0, e.mispredict}, {31'd0, mis});
            compare_field("cond_exec_count", e.cond_exec, ce);
            compare_field("cond_miss_count", e.cond_miss, cm);
            compare_field("jump_exec_count", e.jump_exec, je);
            compare_field("jump_miss_count", e.jump_miss, jm);
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    logic [OP_W-1:0]        i_operation;
    logic [SLOT_IN_W-1:0]   i_slot;
    logic [TARGET_IN_W-1:0] i_actual_target;
    logic                   o_valid;
    logic                   i_stall;
    logic                   o_mispredict;
    logic [TOTAL_W-1:0]     o_cond_exec_count;
    logic [TOTAL_W-1:0]     o_cond_miss_count;
    logic [TOTAL_W-1:0]     o_jump_exec_count;
    logic [TOTAL_W-1:0]     o_jump_miss_count;

    local_history_branch_predictor_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_operation       (i_operation),
        .i_slot            (i_slot),
        .i_actual_target   (i_actual_target),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_mispredict      (o_mispredict),
        .o_cond_exec_count (o_cond_exec_count),
        .o_cond_miss_count (o_cond_miss_count),
        .o_jump_exec_count (o_jump_exec_count),
        .o_jump_miss_count (o_jump_miss_count)
    );

    bp_scoreboard sb = new();

    bit hold_req;
    bit burst_mode;
    int n_cond;
    int n_jump;
    int n_unused;

    // 12 ns clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // offer one item until accepted, then idle for a random gap
    task automatic send_branch(logic [OP_W-1:0] op, logic [SLOT_IN_W-1:0] slot,
                               logic [TARGET_IN_W-1:0] tgt);
        int gap;
        @(negedge i_clk);
        i_valid         = 1'b1;
        i_operation     = op;
        i_slot          = slot;
        i_actual_target = tgt;
        do
            @(posedge i_clk);
        while (o_stall !== 1'b0);
        sb.note_outcome(op, slot, tgt);
        case (op)
            OP_COND_TAKEN, OP_COND_NOT_TAKEN: n_cond++;
            OP_INDIRECT_JUMP:                 n_jump++;
            default:                          n_unused++;
        endcase
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_valid         = 1'b0;
            i_operation     = OP_W'($urandom());
            i_slot          = SLOT_IN_W'($urandom());
            i_actual_target = $urandom();
        end
    endtask

    // stop offering, then wait until every expected result has come
    task automatic drain_results();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // result side: random stalls plus one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req   = 1'b0;
                i_stall    = 1'b0;
                stall_left = 0;
            end else if (stall_left > 0) begin
                i_stall = 1'b1;
                stall_left--;
            end else begin
                i_stall = 1'b0;
                if (!burst_mode && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // check every accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0)
            sb.check_result(o_mispredict, o_cond_exec_count, o_cond_miss_count,
                            o_jump_exec_count, o_jump_miss_count);
    end

    // watchdog on cycles with no handshake on either side
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("%0t ns: timeout, %0d results still expected",
                         $realtime, sb.pending());
                $display("** local_history_branch_predictor_unit: FAILED **");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        logic [SLOT_IN_W-1:0]   pool_slot [POOL];
        logic [7:0]             pool_pat  [POOL];
        int                     pool_len  [POOL];
        int                     pool_pos  [POOL];
        logic [TARGET_IN_W-1:0] pool_tgt  [POOL][2];
        int                     done;
        int                     r;
        int                     k;
        logic [OP_W-1:0]        op;

        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_operation     = OP_COND_TAKEN;
        i_slot          = '0;
        i_actual_target = '0;
        hold_req        = 1'b0;
        burst_mode      = 1'b1;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: counter extremes, history shifts, target hit/miss, unused code
        send_branch(OP_COND_TAKEN, 12'd0, 32'h0);
        send_branch(OP_COND_NOT_TAKEN, 12'd0, 32'h0);
        repeat (4) send_branch(OP_COND_NOT_TAKEN, 12'hFFF, 32'hFFFF_FFFF);
        repeat (3) send_branch(OP_COND_TAKEN, 12'hFFF, 32'h0);
        send_branch(OP_INDIRECT_JUMP, 12'd0, 32'h0);
        send_branch(OP_INDIRECT_JUMP, 12'd0, 32'hFFFF_FFFF);
        send_branch(OP_INDIRECT_JUMP, 12'd0, 32'hFFFF_FFFF);
        send_branch(OP_INDIRECT_JUMP, 12'hFFF, 32'h1234_5678);
        send_branch(OP_UNUSED, 12'd0, $urandom());
        send_branch(OP_UNUSED, 12'hFFF, 32'hFFFF_FFFF);
        send_branch(OP_COND_TAKEN, 12'd0, 32'hFFFF_FFFF);
        repeat (5) send_branch(OP_COND_TAKEN, 12'h5A5, 32'h0);
        send_branch(OP_COND_NOT_TAKEN, 12'h5A5, 32'h0);
        send_branch(OP_INDIRECT_JUMP, 12'hA5A, 32'hFFFF_FFFF);
        send_branch(OP_INDIRECT_JUMP, 12'hA5A, 32'h0);
        drain_results();
        burst_mode = 1'b0;

        // a few hot slots follow repeating outcome patterns and reuse targets
        for (int p = 0; p < POOL; p++) begin
            pool_slot[p]   = SLOT_IN_W'($urandom());
            pool_pat[p]    = 8'($urandom());
            pool_len[p]    = $urandom_range(2, 8);
            pool_pos[p]    = 0;
            pool_tgt[p][0] = $urandom();
            pool_tgt[p][1] = $urandom();
        end

        done = 0;
        while (done < RANDOM_ITEMS) begin
            if (done == 400)
                hold_req = 1'b1;
            if (done == 800)
                drain_results();
            burst_mode = (done >= 1000 && done < 1150);
            r = $urandom_range(0, 99);
            k = $urandom_range(0, POOL - 1);
            if (r < 60) begin
                op = pool_pat[k][pool_pos[k]] ? OP_COND_TAKEN : OP_COND_NOT_TAKEN;
                pool_pos[k] = (pool_pos[k] + 1) % pool_len[k];
                send_branch(op, pool_slot[k], $urandom());
                done++;
            end else if (r < 75) begin
                if ($urandom_range(0, 9) == 0)
                    send_branch(OP_INDIRECT_JUMP, pool_slot[k], $urandom());
                else
                    send_branch(OP_INDIRECT_JUMP, pool_slot[k],
                                pool_tgt[k][$urandom_range(0, 1)]);
                done++;
            end else if (r < 93) begin
                op = OP_W'($urandom_range(0, 2));
                send_branch(op, SLOT_IN_W'($urandom()), $urandom());
                done++;
            end else begin
                send_branch(OP_UNUSED, SLOT_IN_W'($urandom()), $urandom());
            end
        end

        @(negedge i_clk);
        i_valid = 1'b0;
        drain_results();
        repeat (10) @(posedge i_clk);

        $display("Run covered %0d conditional, %0d indirect and %0d unused-code items;",
                 n_cond, n_jump, n_unused);
        $display("%0d results checked, %0d of them mispredictions, %0d errors.",
                 sb.checked, sb.misses_seen, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("** local_history_branch_predictor_unit: PASSED **");
        else
            $display("** local_history_branch_predictor_unit: FAILED **");
        $finish;
    end

endmodule

[files.f]
rtl/lhbp_pkg.sv
rtl/local_history_branch_predictor_unit.sv
verif/tb.sv
